>>> src/ubepf_pkg.sv
// Shared types and constants for the bulk endpoint pair finder.
package ubepf_pkg;

    localparam logic [7:0] NO_IFACE       = 8'hFF;
    localparam logic [7:0] DT_INTERFACE   = 8'h04;
    localparam logic [7:0] DT_ENDPOINT    = 8'h05;
    localparam logic [7:0] IFACE_MIN_LEN  = 8'd9;
    localparam logic [7:0] EP_MIN_LEN     = 8'd7;
    localparam logic [7:0] MIN_DESC_LEN   = 8'd2;
    localparam logic [1:0] XFER_MASK_BULK = 2'b10;
    localparam logic [7:0] CLASS_MSC      = 8'h08;
    localparam logic [7:0] SUBCLASS_SCSI  = 8'h06;
    localparam logic [7:0] PROTO_BOT      = 8'h50;
    localparam logic [7:0] PROTO_UAS      = 8'h62;
    localparam logic [15:0] DEFAULT_MPS   = 16'd64;
    localparam logic [4:0] SCORE_MSC      = 5'd10;
    localparam logic [4:0] SCORE_SCSI     = 5'd2;
    localparam logic [4:0] SCORE_PROTO    = 5'd4;
    localparam int CAP_BYTES              = 6;

    // Descriptor completion event from the parser
    typedef struct packed {
        logic                        iface_done;
        logic                        ep_done;
        logic [CAP_BYTES-1:0][7:0]   cap;
    } desc_evt_t;

    // Result beat contents
    typedef struct packed {
        logic        found;
        logic [7:0]  iface_num;
        logic [7:0]  in_addr;
        logic [15:0] in_mps;
        logic [7:0]  out_addr;
        logic [15:0] out_mps;
    } pair_res_t;

endpackage

>>> src/ubepf_parser.sv
// Descriptor framing: tracks position and length, captures body bytes, flags completion.
module ubepf_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic                  last,
    input  logic [7:0]            data_byte,
    output ubepf_pkg::desc_evt_t  evt
);
    import ubepf_pkg::*;

    logic                      halt_reg, halt_next;
    logic [7:0]                pos_reg, pos_next;
    logic [7:0]                len_reg, len_next;
    logic [7:0]                type_reg, type_next;
    logic [CAP_BYTES-1:0][7:0] cap_reg, cap_next;
    logic                      done;
    logic                      strobe;
    logic [2:0]                cap_idx;

    assign cap_idx = pos_reg[2:0] - 3'd2;
    assign done    = ({1'b0, pos_reg} + 9'd1) >= {1'b0, len_reg};

    always_comb begin
        halt_next = halt_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        type_next = type_reg;
        cap_next  = cap_reg;
        if (!halt_reg) begin
            if (pos_reg == 8'd0) begin
                len_next = data_byte;
                if (data_byte < MIN_DESC_LEN) begin
                    halt_next = 1'b1;
                end
            end else if (pos_reg == 8'd1) begin
                type_next = data_byte;
            end else if (pos_reg < 8'd8) begin
                cap_next[cap_idx] = data_byte;
            end
            if (!halt_next) begin
                if (pos_reg != 8'd0 && done) begin
                    pos_next = 8'd0;
                end else begin
                    pos_next = pos_reg + 8'd1;
                end
            end
        end
    end

    // Required body bytes always land before the closing byte, so the
    // registered captures are complete when the descriptor ends.
    assign strobe         = !halt_reg && pos_reg != 8'd0 && done;
    assign evt.iface_done = strobe && type_reg == DT_INTERFACE && len_reg >= IFACE_MIN_LEN;
    assign evt.ep_done    = strobe && type_reg == DT_ENDPOINT && len_reg >= EP_MIN_LEN
                            && (cap_reg[1][1:0] == XFER_MASK_BULK);
    assign evt.cap        = cap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg <= 1'b0;
            pos_reg  <= 8'd0;
            len_reg  <= 8'd0;
            type_reg <= 8'd0;
        end else if (go) begin
            if (last) begin
                halt_reg <= 1'b0;
                pos_reg  <= 8'd0;
                len_reg  <= 8'd0;
                type_reg <= 8'd0;
            end else begin
                halt_reg <= halt_next;
                pos_reg  <= pos_next;
                len_reg  <= len_next;
                type_reg <= type_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (go) begin
            cap_reg <= cap_next;
        end
    end

endmodule

>>> src/ubepf_selector.sv
// Interface context, endpoint scoring and best pair selection.
module ubepf_selector (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  go,
    input  logic                  last,
    input  ubepf_pkg::desc_evt_t  evt,
    output ubepf_pkg::pair_res_t  res
);
    import ubepf_pkg::*;

    logic [7:0]  cur_if_reg, cur_if_next;
    logic [7:0]  cur_alt_reg, cur_alt_next;
    logic [7:0]  cur_cls_reg, cur_cls_next;
    logic [7:0]  cur_sub_reg, cur_sub_next;
    logic [7:0]  cur_proto_reg, cur_proto_next;
    logic        best_set_reg, best_set_next;
    logic [4:0]  best_score_reg, best_score_next;
    logic [7:0]  best_if_reg, best_if_next;
    logic [7:0]  in_addr_reg, in_addr_next;
    logic [7:0]  out_addr_reg, out_addr_next;
    logic [15:0] in_mps_reg, in_mps_next;
    logic [15:0] out_mps_reg, out_mps_next;

    logic [4:0]  score;
    logic [15:0] mps;
    logic        take;

    always_comb begin
        score = 5'd0;
        if (cur_cls_reg == CLASS_MSC) begin
            score = SCORE_MSC;
            if (cur_sub_reg == SUBCLASS_SCSI) begin
                score = score + SCORE_SCSI;
            end
            if (cur_proto_reg == PROTO_BOT || cur_proto_reg == PROTO_UAS) begin
                score = score + SCORE_PROTO;
            end
        end
        mps = {evt.cap[3], evt.cap[2]};
        if (mps == 16'd0) begin
            mps = DEFAULT_MPS;
        end
    end

    always_comb begin
        cur_if_next     = cur_if_reg;
        cur_alt_next    = cur_alt_reg;
        cur_cls_next    = cur_cls_reg;
        cur_sub_next    = cur_sub_reg;
        cur_proto_next  = cur_proto_reg;
        best_set_next   = best_set_reg;
        best_score_next = best_score_reg;
        best_if_next    = best_if_reg;
        in_addr_next    = in_addr_reg;
        out_addr_next   = out_addr_reg;
        in_mps_next     = in_mps_reg;
        out_mps_next    = out_mps_reg;
        take            = 1'b0;
        if (evt.iface_done) begin
            cur_if_next    = evt.cap[0];
            cur_alt_next   = evt.cap[1];
            cur_cls_next   = evt.cap[3];
            cur_sub_next   = evt.cap[4];
            cur_proto_next = evt.cap[5];
        end else if (evt.ep_done && cur_if_reg != NO_IFACE && cur_alt_reg == 8'd0) begin
            if (!best_set_reg || score > best_score_reg) begin
                // new leader: drop endpoints chosen so far
                best_set_next   = 1'b1;
                best_score_next = score;
                best_if_next    = cur_if_reg;
                in_addr_next    = 8'd0;
                out_addr_next   = 8'd0;
                in_mps_next     = 16'd0;
                out_mps_next    = 16'd0;
                take            = 1'b1;
            end else if (score == best_score_reg && cur_if_reg == best_if_reg) begin
                take = 1'b1;
            end
            if (take) begin
                if (evt.cap[0][7]) begin
                    in_addr_next = evt.cap[0];
                    in_mps_next  = mps;
                end else begin
                    out_addr_next = evt.cap[0];
                    out_mps_next  = mps;
                end
            end
        end
    end

    always_comb begin
        res.found = best_set_next && in_addr_next != 8'd0 && out_addr_next != 8'd0;
        if (res.found) begin
            res.iface_num = best_if_next;
            res.in_addr   = in_addr_next;
            res.in_mps    = in_mps_next;
            res.out_addr  = out_addr_next;
            res.out_mps   = out_mps_next;
        end else begin
            res.iface_num = NO_IFACE;
            res.in_addr   = 8'd0;
            res.in_mps    = 16'd0;
            res.out_addr  = 8'd0;
            res.out_mps   = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (go && last)) begin
            cur_if_reg     <= NO_IFACE;
            cur_alt_reg    <= 8'd0;
            cur_cls_reg    <= 8'd0;
            cur_sub_reg    <= 8'd0;
            cur_proto_reg  <= 8'd0;
            best_set_reg   <= 1'b0;
            best_score_reg <= 5'd0;
            best_if_reg    <= NO_IFACE;
            in_addr_reg    <= 8'd0;
            out_addr_reg   <= 8'd0;
            in_mps_reg     <= 16'd0;
            out_mps_reg    <= 16'd0;
        end else if (go) begin
            cur_if_reg     <= cur_if_next;
            cur_alt_reg    <= cur_alt_next;
            cur_cls_reg    <= cur_cls_next;
            cur_sub_reg    <= cur_sub_next;
            cur_proto_reg  <= cur_proto_next;
            best_set_reg   <= best_set_next;
            best_score_reg <= best_score_next;
            best_if_reg    <= best_if_next;
            in_addr_reg    <= in_addr_next;
            out_addr_reg   <= out_addr_next;
            in_mps_reg     <= in_mps_next;
            out_mps_reg    <= out_mps_next;
        end
    end

endmodule

>>> src/usb_bulk_endpoint_pair_finder_core.sv
// Top level: input beat register, parser, selector and result register.
//
//  channel | dir | tdata                                   | tuser  | tlast
//  s_      | in  | [7:0] data_byte                         | -      | last_byte
//  m_      | out | [7:0] interface_number, [15:8] in addr, | found  | -
//          |     | [31:16] in mps, [39:32] out addr,       |        |
//          |     | [55:40] out mps                         |        |
//
// One byte per cycle sustained while no last-marked byte is held back by a waiting
// result: each byte goes from the input register through the parser and selector update.
// A result is registered as its last-marked byte is processed and appears in the cycle after.
// A waiting result stalls only a following last-marked byte; other bytes flow on.
// Synchronous active-low reset clears the parse and selection state, but not the parser's captured body bytes.
module usb_bulk_endpoint_pair_finder_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // interface_number, in_endpoint_address, in_max_packet,
                                   // out_endpoint_address, out_max_packet
    output logic        m_tuser    // found
);
    import ubepf_pkg::*;

    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_vld_reg, out_vld_next;
    pair_res_t  out_res_reg;
    logic       go;
    logic       s_acc;
    desc_evt_t  evt;
    pair_res_t  res;

    assign go       = in_vld_reg && (!in_last_reg || !out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || go;
    assign s_acc    = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_acc) begin
            in_vld_next = 1'b1;
        end else if (go) begin
            in_vld_next = 1'b0;
        end
        out_vld_next = out_vld_reg;
        if (go && in_last_reg) begin
            out_vld_next = 1'b1;
        end else if (m_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (go && in_last_reg) begin
            out_res_reg <= res;
        end
    end

    ubepf_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .go        (go),
        .last      (in_last_reg),
        .data_byte (in_byte_reg),
        .evt       (evt)
    );

    ubepf_selector u_selector (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (go),
        .last    (in_last_reg),
        .evt     (evt),
        .res     (res)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tuser  = out_res_reg.found;
    assign m_tdata  = {out_res_reg.out_mps, out_res_reg.out_addr, out_res_reg.in_mps,
                       out_res_reg.in_addr, out_res_reg.iface_num};

endmodule

>>> sim/tb_top.sv
// Testbench for the bulk endpoint pair finder: descriptor byte stream in, pair result checked.
module tb_top;
    import ubepf_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int TARGET_BYTES = 1350;

    typedef struct {
        logic [7:0] b;
        logic       last;
        bit         hold;   // wait for all results before sending this beat
    } byte_item_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        m_tuser;

    usb_bulk_endpoint_pair_finder_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    byte_item_t feed_q[$];
    pair_res_t  pending_pairs[$];

    int  errors = 0;
    int  bytes_taken = 0;
    int  results_seen = 0;
    int  pairs_found = 0;
    int  cycle_count = 0;
    int  feed_gap = 0;
    int  sink_stall = 0;
    bit  byte_taken = 1'b0;
    bit  calm = 1'b0;

    // parser and selector state as the block should hold it
    logic [7:0]  pos_in_desc;
    logic [7:0]  desc_len;
    logic [7:0]  desc_type;
    logic [7:0]  desc_body [6];
    logic        halted;
    logic [7:0]  cur_if, cur_alt, cur_class, cur_sub, cur_proto;
    logic [7:0]  pick_if, pick_in, pick_out;
    logic [15:0] pick_in_mps, pick_out_mps;
    int          pick_score;

    function automatic void clear_parser();
        pos_in_desc = 8'd0;
        desc_len = 8'd0;
        desc_type = 8'd0;
        foreach (desc_body[i]) desc_body[i] = 8'd0;
        halted = 1'b0;
        cur_if = NO_IFACE;
        cur_alt = 8'd0;
        cur_class = 8'd0;
        cur_sub = 8'd0;
        cur_proto = 8'd0;
        pick_if = NO_IFACE;
        pick_in = 8'd0;
        pick_out = 8'd0;
        pick_in_mps = 16'd0;
        pick_out_mps = 16'd0;
        pick_score = -1;
    endfunction

    // Runs when the final byte of a descriptor has arrived
    function automatic void close_descriptor();
        logic [15:0] mps;
        int score;
        bit take;
        if (desc_type == DT_INTERFACE && desc_len >= IFACE_MIN_LEN) begin
            cur_if = desc_body[0];
            cur_alt = desc_body[1];
            cur_class = desc_body[3];
            cur_sub = desc_body[4];
            cur_proto = desc_body[5];
        end else if (desc_type == DT_ENDPOINT && desc_len >= EP_MIN_LEN &&
                     cur_if != NO_IFACE && cur_alt == 8'd0 &&
                     desc_body[1][1:0] == XFER_MASK_BULK) begin
            mps = {desc_body[3], desc_body[2]};
            score = 0;
            if (cur_class == CLASS_MSC) begin
                score = SCORE_MSC;
                if (cur_sub == SUBCLASS_SCSI)
                    score += SCORE_SCSI;
                if (cur_proto == PROTO_BOT || cur_proto == PROTO_UAS)
                    score += SCORE_PROTO;
            end
            if (score > pick_score) begin
                pick_score = score;
                pick_if = cur_if;
                pick_in = 8'd0;
                pick_out = 8'd0;
                pick_in_mps = 16'd0;
                pick_out_mps = 16'd0;
                take = 1'b1;
            end else begin
                take = (score == pick_score) && (cur_if == pick_if);
            end
            if (take) begin
                if (mps == 16'd0)
                    mps = DEFAULT_MPS;
                if (desc_body[0][7]) begin
                    pick_in = desc_body[0];
                    pick_in_mps = mps;
                end else begin
                    pick_out = desc_body[0];
                    pick_out_mps = mps;
                end
            end
        end
    endfunction

    function automatic void track_byte(input logic [7:0] b, input logic last);
        bit done;
        pair_res_t r;
        if (!halted) begin
            done = 1'b0;
            if (pos_in_desc == 8'd0) begin
                desc_len = b;
                if (b < MIN_DESC_LEN)
                    halted = 1'b1;
            end else begin
                if (pos_in_desc == 8'd1)
                    desc_type = b;
                else if (pos_in_desc < 8'd8)
                    desc_body[pos_in_desc - 8'd2] = b;
                if (int'(pos_in_desc) + 1 >= int'(desc_len))
                    done = 1'b1;
            end
            if (!halted) begin
                if (done) begin
                    close_descriptor();
                    pos_in_desc = 8'd0;
                end else begin
                    pos_in_desc = pos_in_desc + 8'd1;
                end
            end
        end
        if (last) begin
            r = '0;
            r.iface_num = NO_IFACE;
            if (pick_in != 8'd0 && pick_out != 8'd0 && pick_score >= 0) begin
                r.found = 1'b1;
                r.iface_num = pick_if;
                r.in_addr = pick_in;
                r.in_mps = pick_in_mps;
                r.out_addr = pick_out;
                r.out_mps = pick_out_mps;
            end
            pending_pairs.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void cmp_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_result();
        pair_res_t want;
        if (pending_pairs.size() == 0) begin
            $error("result beat with no expectation waiting");
            errors++;
        end else begin
            want = pending_pairs.pop_front();
            results_seen++;
            if (want.found)
                pairs_found++;
            cmp_field("found", 16'(want.found), 16'(m_tuser));
            cmp_field("interface_number", 16'(want.iface_num), 16'(m_tdata[7:0]));
            cmp_field("in_endpoint_address", 16'(want.in_addr), 16'(m_tdata[15:8]));
            cmp_field("in_max_packet", want.in_mps, m_tdata[31:16]);
            cmp_field("out_endpoint_address", 16'(want.out_addr), 16'(m_tdata[39:32]));
            cmp_field("out_max_packet", want.out_mps, m_tdata[55:40]);
        end
    endfunction

    // Mostly back-to-back, often a short gap, now and then a long one; calm phases have none at all
    function automatic int pick_gap();
        int r;
        if ($urandom_range(0, 149) == 0)
            calm = !calm;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------- stimulus building ----------------

    function automatic void queue_byte(input logic [7:0] b);
        byte_item_t it;
        it.b = b;
        it.last = 1'b0;
        it.hold = 1'b0;
        feed_q.push_back(it);
    endfunction

    function automatic void close_block();
        feed_q[feed_q.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [55:0] rand56();
        return 56'({$urandom, $urandom});
    endfunction

    // body holds bytes 2..8 of the descriptor, lowest byte first
    function automatic void put_desc(input int len, input logic [7:0] typ,
                                     input logic [55:0] body);
        for (int p = 0; p < len; p++) begin
            if (p == 0)
                queue_byte(8'(len));
            else if (p == 1)
                queue_byte(typ);
            else if (p <= 8)
                queue_byte(body[8*(p-2) +: 8]);
            else
                queue_byte(8'($urandom));
        end
    endfunction

    function automatic void put_interface();
        int len;
        logic [7:0] ifn, alt, cls, sub, proto;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 12) : 9;
        ifn = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        if ($urandom_range(0, 29) == 0)
            ifn = NO_IFACE;
        alt = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        cls = ($urandom_range(0, 4) < 3) ? CLASS_MSC : 8'($urandom);
        sub = ($urandom_range(0, 4) < 3) ? SUBCLASS_SCSI : 8'($urandom);
        case ($urandom_range(0, 2))
            0: proto = PROTO_BOT;
            1: proto = PROTO_UAS;
            default: proto = 8'($urandom);
        endcase
        put_desc(len, DT_INTERFACE, {8'($urandom), proto, sub, cls, 8'($urandom), alt, ifn});
    endfunction

    function automatic void put_endpoint();
        int len, r;
        logic [7:0] addr, attr;
        logic [15:0] mps;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, 10) : 7;
        r = $urandom_range(0, 99);
        if (r < 45)
            addr = {4'b1000, 4'($urandom)};
        else if (r < 90)
            addr = {4'b0000, 4'($urandom)};
        else if (r < 95)
            addr = 8'h00;
        else
            addr = 8'($urandom);
        attr = ($urandom_range(0, 19) < 17) ? {6'($urandom), XFER_MASK_BULK} : 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 20)
            mps = 16'd0;
        else if (r < 25)
            mps = 16'($urandom);
        else if (r < 28)
            mps = 16'hFFFF;
        else
            mps = 16'($urandom_range(1, 1023));
        put_desc(len, DT_ENDPOINT, {8'($urandom), 8'($urandom), 8'($urandom),
                                    mps[15:8], mps[7:0], attr, addr});
    endfunction

    // Configuration block: header, interfaces, their endpoints, with occasional faults
    function automatic void gen_config_block();
        int start, n_if, n_ep;
        start = feed_q.size();
        if ($urandom_range(0, 9) == 0)
            put_endpoint();   // endpoint before any interface
        put_desc(9, 8'h02, rand56());
        n_if = $urandom_range(1, 3);
        for (int i = 0; i < n_if; i++) begin
            put_interface();
            n_ep = $urandom_range(1, 3);
            for (int k = 0; k < n_ep; k++)
                put_endpoint();
            if ($urandom_range(0, 7) == 0)
                put_desc($urandom_range(2, 12), 8'($urandom), rand56());
            if ($urandom_range(0, 24) == 0)
                queue_byte(8'($urandom_range(0, 1)));   // bad length stops the parse
        end
        if ($urandom_range(0, 9) == 0) begin
            n_ep = $urandom_range(start + 1, feed_q.size());
            while (feed_q.size() > n_ep)
                void'(feed_q.pop_back());
        end
        if ($urandom_range(0, 11) == 0)
            feed_q[start].hold = 1'b1;
        close_block();
    endfunction

    // Loose mixture of descriptors and raw bytes
    function automatic void gen_noise_block();
        int n;
        logic [7:0] typ;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 4))
                0: put_interface();
                1: put_endpoint();
                2: begin
                    typ = ($urandom_range(0, 1) == 0) ? DT_INTERFACE : DT_ENDPOINT;
                    put_desc($urandom_range(2, 16), typ, rand56());
                end
                3: put_desc(($urandom_range(0, 39) == 0) ? 255 : $urandom_range(2, 16),
                            8'($urandom), rand56());
                default: begin
                    repeat ($urandom_range(1, 6)) queue_byte(8'($urandom));
                end
            endcase
        end
        close_block();
    endfunction

    // ---------------- driver and monitor ----------------

    always @(posedge aclk) begin
        byte_taken = s_tvalid && s_tready;
        if (aresetn) begin
            if (byte_taken) begin
                bytes_taken++;
                track_byte(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
                check_result();
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_tvalid || byte_taken)) begin
            if (feed_gap > 0) begin
                feed_gap--;
                s_tvalid <= 1'b0;
            end else if (feed_q.size() > 0 &&
                         !(feed_q[0].hold && pending_pairs.size() > 0)) begin
                s_tvalid <= 1'b1;
                s_tdata <= feed_q[0].b;
                s_tlast <= feed_q[0].last;
                void'(feed_q.pop_front());
                feed_gap = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            if (sink_stall > 0) begin
                sink_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                sink_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        clear_parser();

        // MSC/SCSI/BOT interface with IN (size 0 -> 64) and OUT (max size) bulk pair
        put_desc(9, DT_INTERFACE, {8'h00, PROTO_BOT, SUBCLASS_SCSI, CLASS_MSC,
                                   8'h02, 8'h00, 8'h00});
        put_desc(7, DT_ENDPOINT, {8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                                  6'b0, XFER_MASK_BULK, 8'h81});
        put_desc(7, DT_ENDPOINT, {8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF,
                                  6'b0, XFER_MASK_BULK, 8'h02});
        close_block();
        // zero length on its own, sent only once the first result is out
        queue_byte(8'h00);
        feed_q[feed_q.size() - 1].hold = 1'b1;
        close_block();
        // length one, then an ignored all-ones byte
        queue_byte(8'h01);
        queue_byte(8'hFF);
        close_block();
        // interface descriptor cut short by the last beat
        queue_byte(8'd9);
        queue_byte(DT_INTERFACE);
        queue_byte(8'h00);
        close_block();

        while (feed_q.size() < TARGET_BYTES) begin
            if ($urandom_range(0, 3) == 0)
                gen_noise_block();
            else
                gen_config_block();
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (feed_q.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (pending_pairs.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d descriptor bytes in %0d blocks; %0d results checked,",
                 bytes_taken, results_seen, results_seen);
        $display("%0d of them with a bulk IN/OUT pair chosen.", pairs_found);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
